// ===== sv/sldd_pkg.sv =====
// ----------------------------------------------------------------------------
// sldd_pkg
// Word types, zigzag scan tables and step record for the scaling list
// delta decoder.
// ----------------------------------------------------------------------------
package sldd_pkg;

   // input word: one decoded delta, list size on the first word of a list
   typedef struct packed {
      logic signed [7:0] delta_value;
      logic              list_8x8;
   } req_type;

   // output word: one list entry
   typedef struct packed {
      logic [5:0] entry_index;
      logic [7:0] entry_value;
      logic       use_default;
      logic       last_entry;
   } rsp_type;

   // operands handed to the scale unit
   typedef struct packed {
      logic [7:0] scale;
      logic [7:0] delta;
      logic [5:0] pos;
      logic       is_8x8;
   } step_in_type;

   // results returned by the scale unit
   typedef struct packed {
      logic [7:0] next_scale;
      logic       scale_zero;
      logic [5:0] raster;
      logic       at_last;
   } step_out_type;

   localparam logic [7:0] SCALE_INIT = 8'd8;
   localparam logic [5:0] LAST_POS_4X4 = 6'd15;
   localparam logic [5:0] LAST_POS_8X8 = 6'd63;

   // 4x4 zigzag scan, scan position to raster position
   localparam logic [5:0] ZIGZAG_4X4 [16] = '{
      6'd0, 6'd1, 6'd4, 6'd8, 6'd5, 6'd2, 6'd3, 6'd6,
      6'd9, 6'd12, 6'd13, 6'd10, 6'd7, 6'd11, 6'd14, 6'd15
   };

   // 8x8 zigzag scan, scan position to raster position
   localparam logic [5:0] ZIGZAG_8X8 [64] = '{
      6'd0, 6'd1, 6'd8, 6'd16, 6'd9, 6'd2, 6'd3, 6'd10,
      6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4, 6'd5,
      6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
      6'd27, 6'd20, 6'd13, 6'd6, 6'd7, 6'd14, 6'd21, 6'd28,
      6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
      6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
      6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
      6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
   };

endpackage

// ===== sv/sldd_scale_unit.sv =====
// ----------------------------------------------------------------------------
// sldd_scale_unit
// Shared step unit: modulo-256 scale update, zero test, zigzag lookup and
// end-of-list compare for the current scan position.
// ----------------------------------------------------------------------------
module sldd_scale_unit (
   input  sldd_pkg::step_in_type  step_in,
   output sldd_pkg::step_out_type step_out
);

   logic [5:0] last_pos;

   always_comb begin
      // scale update wraps at 256 by width
      step_out.next_scale = step_in.scale + step_in.delta;
      step_out.scale_zero = (step_out.next_scale == 8'd0);
      // raster position through the zigzag scan of the selected size
      if (step_in.is_8x8) begin
         step_out.raster = sldd_pkg::ZIGZAG_8X8[step_in.pos];
         last_pos        = sldd_pkg::LAST_POS_8X8;
      end else begin
         step_out.raster = sldd_pkg::ZIGZAG_4X4[step_in.pos[3:0]];
         last_pos        = sldd_pkg::LAST_POS_4X4;
      end
      step_out.at_last = (step_in.pos == last_pos);
   end

endmodule

// ===== sv/scaling_list_delta_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// scaling_list_delta_decoder_unit
// Rebuilds a 16-entry or 64-entry scaling list from decoded deltas.
// ----------------------------------------------------------------------------
// Each accepted delta word yields one entry word in the next cycle, so deltas
// run at one per cycle as long as rsp_ready keeps the output register
// draining. A delta whose new scale is zero starts a fill run: the current
// and every remaining entry are sent with the last scale, one per cycle
// while rsp_ready is high, and req_ready stays low until the final entry is
// loaded; a run sends at most 64 entries for an 8x8 list and 16 for a 4x4
// list. The entry rate is set by the single output register and the one
// shared scale unit (adder, zigzag lookup and end compare) that serves both
// deltas and fill entries.
module scaling_list_delta_decoder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sldd_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sldd_pkg::rsp_type rsp_word
);

   typedef enum logic {
      S_IDLE,
      S_FILL
   } state_type;

   state_type         state_ff, state_in;
   logic [5:0]        pos_ff, pos_in;
   logic [7:0]        last_scale_ff, last_scale_in;
   logic              large_ff, large_in;
   logic              active_ff, active_in;
   logic              default_ff, default_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sldd_pkg::rsp_type rsp_ff, rsp_in;

   sldd_pkg::step_in_type  step_in;
   sldd_pkg::step_out_type step_out;
   logic                   req_take;
   logic                   rsp_take;
   logic                   first_zero;

   assign rsp_take  = rsp_valid_ff && rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // operands: a new list starts from scale 8 at scan position 0
   always_comb begin
      step_in.delta = req_word.delta_value;
      if (active_ff) begin
         step_in.scale  = last_scale_ff;
         step_in.pos    = pos_ff;
         step_in.is_8x8 = large_ff;
      end else begin
         step_in.scale  = sldd_pkg::SCALE_INIT;
         step_in.pos    = 6'd0;
         step_in.is_8x8 = req_word.list_8x8;
      end
   end

   sldd_scale_unit u_scale (
      .step_in  (step_in),
      .step_out (step_out)
   );

   assign first_zero = (step_in.pos == 6'd0);

   // sequencer: delta words in idle, repeated entries in fill
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      last_scale_in = last_scale_ff;
      large_in      = large_ff;
      active_in     = active_ff;
      default_in    = default_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               rsp_valid_in         = 1'b1;
               rsp_in.entry_index   = step_out.raster;
               rsp_in.last_entry    = step_out.at_last;
               large_in             = step_in.is_8x8;
               active_in            = 1'b1;
               if (step_out.scale_zero) begin
                  default_in         = active_ff ? default_ff : first_zero;
                  if (first_zero) begin
                     default_in      = 1'b1;
                  end
                  rsp_in.entry_value = step_in.scale;
                  last_scale_in      = step_in.scale;
                  rsp_in.use_default = step_out.at_last && default_in;
                  if (!step_out.at_last) begin
                     state_in        = S_FILL;
                  end
               end else begin
                  default_in         = active_ff ? default_ff : 1'b0;
                  rsp_in.entry_value = step_out.next_scale;
                  last_scale_in      = step_out.next_scale;
                  rsp_in.use_default = step_out.at_last && default_in;
               end
               if (step_out.at_last) begin
                  active_in          = 1'b0;
                  pos_in             = 6'd0;
                  last_scale_in      = sldd_pkg::SCALE_INIT;
                  default_in         = 1'b0;
               end else begin
                  pos_in             = step_in.pos + 6'd1;
               end
            end
         end
         S_FILL: begin
            if (rsp_take) begin
               rsp_valid_in         = 1'b1;
               rsp_in.entry_index   = step_out.raster;
               rsp_in.entry_value   = last_scale_ff;
               rsp_in.last_entry    = step_out.at_last;
               rsp_in.use_default   = step_out.at_last && default_ff;
               if (step_out.at_last) begin
                  state_in          = S_IDLE;
                  active_in         = 1'b0;
                  pos_in            = 6'd0;
                  last_scale_in     = sldd_pkg::SCALE_INIT;
                  default_in        = 1'b0;
               end else begin
                  pos_in            = pos_ff + 6'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered output word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pos_ff        <= 6'd0;
         last_scale_ff <= sldd_pkg::SCALE_INIT;
         large_ff      <= 1'b0;
         active_ff     <= 1'b0;
         default_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         last_scale_ff <= last_scale_in;
         large_ff      <= large_in;
         active_ff     <= active_in;
         default_ff    <= default_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // a fill run always has an entry waiting
   a_fill_has_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |-> rsp_valid_ff)
      else $error("fill state without a pending entry word");

   // entries of a fill run repeat the same scale
   a_fill_same_value: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL && rsp_take) |=>
         (rsp_valid_ff && rsp_ff.entry_value == $past(rsp_ff.entry_value)))
      else $error("fill run changed the entry value");

   // use-default is only reported on the final entry
   a_default_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.use_default) |-> rsp_ff.last_entry)
      else $error("use_default set on an entry that is not the last");

   // a stored scale is never zero
   a_value_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.entry_value != 8'd0))
      else $error("zero entry value sent");

endmodule

// ===== test/scale_entry_board_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scale_entry_board_pkg
// Entry predictor and scoreboard for the scaling list delta decoder test.
// Rebuilds each list from the accepted deltas, queues the entry words the
// block should send and compares every sent entry word against them.
// ----------------------------------------------------------------------------
package scale_entry_board_pkg;

   // scan position to raster position, 4x4 list
   localparam logic [5:0] RASTER_4X4 [16] = '{
      6'd0, 6'd1, 6'd4, 6'd8, 6'd5, 6'd2, 6'd3, 6'd6,
      6'd9, 6'd12, 6'd13, 6'd10, 6'd7, 6'd11, 6'd14, 6'd15
   };

   // scan position to raster position, 8x8 list
   localparam logic [5:0] RASTER_8X8 [64] = '{
      6'd0, 6'd1, 6'd8, 6'd16, 6'd9, 6'd2, 6'd3, 6'd10,
      6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4, 6'd5,
      6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
      6'd27, 6'd20, 6'd13, 6'd6, 6'd7, 6'd14, 6'd21, 6'd28,
      6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
      6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
      6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
      6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
   };

   localparam logic [7:0] START_SCALE = 8'd8;
   localparam int         MAX_PRINTED = 100;

   class scale_entry_board;

      // list state as the block should hold it
      logic [7:0] cur_scale = START_SCALE;
      int         scan_pos = 0;
      logic       large_list = 1'b0;
      logic       in_list = 1'b0;
      logic       dflt_flag = 1'b0;

      sldd_pkg::rsp_type pending_entries [$];
      int                entries_checked = 0;
      int                mismatch_count = 0;

      // queue one entry word at the current scan position
      function void push_entry(logic [7:0] value, logic is_final);
         sldd_pkg::rsp_type e;
         e.entry_index = large_list ? RASTER_8X8[scan_pos] : RASTER_4X4[scan_pos];
         e.entry_value = value;
         e.use_default = is_final ? dflt_flag : 1'b0;
         e.last_entry  = is_final;
         pending_entries.push_back(e);
      endfunction

      // accepted delta word: work out every entry word it causes
      function void note_delta(sldd_pkg::req_type w);
         logic [7:0] nxt;
         int         len;
         if (!in_list) begin
            in_list    = 1'b1;
            large_list = w.list_8x8;
            scan_pos   = 0;
            cur_scale  = START_SCALE;
            dflt_flag  = 1'b0;
         end
         len = large_list ? 64 : 16;
         if (scan_pos >= len)
            scan_pos = len - 1;
         nxt = cur_scale + $unsigned(w.delta_value);
         if (nxt == 8'd0) begin
            // zero scale: repeat the last scale up to the end of the list
            if (scan_pos == 0)
               dflt_flag = 1'b1;
            while (scan_pos < len) begin
               push_entry(cur_scale, scan_pos + 1 == len);
               scan_pos++;
            end
         end else begin
            cur_scale = nxt;
            push_entry(cur_scale, scan_pos + 1 == len);
            scan_pos++;
         end
         // list complete, back to idle
         if (scan_pos >= len) begin
            in_list   = 1'b0;
            scan_pos  = 0;
            cur_scale = START_SCALE;
            dflt_flag = 1'b0;
         end
      endfunction

      task report_mismatch(string what, int got_v, int exp_v);
         if (mismatch_count < MAX_PRINTED)
            $display("%0t mismatch on entry word %0d: %s got %0d expected %0d",
                     $time, entries_checked, what, got_v, exp_v);
         mismatch_count++;
      endtask

      // sent entry word against the oldest expectation
      task check_entry(sldd_pkg::rsp_type got);
         sldd_pkg::rsp_type exp_w;
         if (pending_entries.size() == 0) begin
            report_mismatch("unexpected word, index", got.entry_index, -1);
         end else begin
            exp_w = pending_entries.pop_front();
            if (got.entry_index != exp_w.entry_index)
               report_mismatch("entry_index", got.entry_index, exp_w.entry_index);
            if (got.entry_value != exp_w.entry_value)
               report_mismatch("entry_value", got.entry_value, exp_w.entry_value);
            if (got.use_default != exp_w.use_default)
               report_mismatch("use_default", got.use_default, exp_w.use_default);
            if (got.last_entry != exp_w.last_entry)
               report_mismatch("last_entry", got.last_entry, exp_w.last_entry);
         end
         entries_checked++;
      endtask

   endclass

endpackage

// ===== test/scaling_list_delta_decoder_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaling_list_delta_decoder_unit_test
// Self-checking test of the scaling list delta decoder. Directed lists cover
// default lists, scale wrap, zero fills at first, middle and final positions
// and size changes inside a list; random lists follow, mostly well formed
// with some noise. The sender works in bursts and the receiver stalls on its
// own pattern, with one long receiver hold-off and one full drain.
// ----------------------------------------------------------------------------
module scaling_list_delta_decoder_unit_test;

   localparam int TOTAL_WORDS = 380;
   localparam int HOLD_CYCLES = 120;
   localparam int TAIL_CYCLES = 100;

   // deltas of the directed 4x4 list, full range then back
   localparam logic [7:0] CLIMB_DELTAS [15] = '{
      8'd127, 8'h80, 8'd0, 8'd1, 8'hff, 8'd100, 8'd127, 8'h80,
      8'd64, 8'hc0, 8'd3, 8'hfd, 8'd127, 8'd127, 8'd0
   };

   typedef enum logic [1:0] {
      DRAIN_FREE,
      DRAIN_RANDOM,
      DRAIN_SLOW
   } drain_mode_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   sldd_pkg::req_type req_word = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   sldd_pkg::rsp_type rsp_word;

   scale_entry_board_pkg::scale_entry_board entry_board = new();

   int             words_sent = 0;
   int             burst_left = 4;
   int             hold_seq = 0;
   int             hold_seen = 0;
   int             hold_left = 0;
   int             mode_left = 0;
   drain_mode_type drain_mode = DRAIN_FREE;

   scaling_list_delta_decoder_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   function automatic sldd_pkg::req_type make_word(logic [7:0] d, logic size_8x8);
      sldd_pkg::req_type w;
      w.delta_value = d;
      w.list_8x8    = size_8x8;
      return w;
   endfunction

   // delta that keeps the running scale away from zero
   function automatic logic [7:0] keep_nonzero(logic [7:0] d);
      logic [7:0] sum;
      sum = entry_board.cur_scale + d;
      return (sum == 8'd0) ? d + 8'd1 : d;
   endfunction

   function automatic logic [7:0] zero_delta();
      return 8'd0 - entry_board.cur_scale;
   endfunction

   function automatic logic [7:0] pick_delta();
      logic [7:0] d;
      if ($urandom_range(0, 1) == 1)
         d = 8'($urandom_range(0, 8)) - 8'd4;
      else
         d = 8'($urandom_range(0, 255));
      return keep_nonzero(d);
   endfunction

   task automatic sender_pause(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // offer one delta word and hold it until accepted
   task automatic send_word(sldd_pkg::req_type w);
      int gap;
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      entry_board.note_delta(w);
      words_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0)
            sender_pause(gap);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 12);
      end
   endtask

   task automatic wait_drained();
      while (entry_board.pending_entries.size() != 0) @(posedge clock);
   endtask

   // one list: random deltas, zero at a random position or none at all
   task automatic send_list();
      logic size_8x8;
      int   len;
      int   stop;
      size_8x8 = ($urandom_range(0, 2) == 0);
      len      = size_8x8 ? 64 : 16;
      stop     = ($urandom_range(0, 3) == 0) ? len : $urandom_range(0, len - 1);
      for (int k = 0; k < len; k++) begin
         if (k == stop) begin
            send_word(make_word(zero_delta(), (k == 0) ? size_8x8 : 1'($urandom)));
            break;
         end
         send_word(make_word(pick_delta(), (k == 0) ? size_8x8 : 1'($urandom)));
      end
   endtask

   // reset
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // receiver: check each entry word, then choose next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         entry_board.check_entry(rsp_word);
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            drain_mode = drain_mode_type'($urandom_range(0, 2));
            mode_left  = $urandom_range(10, 60);
         end
         mode_left--;
         case (drain_mode)
            DRAIN_FREE:   rsp_ready <= 1'b1;
            DRAIN_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
            default:      rsp_ready <= (mode_left % 4 == 0);
         endcase
      end
   end

   // stimulus
   initial begin
      int  kind;
      int  noise;
      bit  hold_done;
      bit  pause_done;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);

      // default lists: first delta gives zero, 4x4 then 8x8
      send_word(make_word(8'hf8, 1'b0));
      send_word(make_word(8'hf8, 1'b1));

      // 8x8 scale climbs to 255 and wraps to zero, size bit ignored mid list
      send_word(make_word(8'd127, 1'b1));
      send_word(make_word(8'd120, 1'b0));
      send_word(make_word(8'd1, 1'b0));

      // 4x4 list through the delta extremes, zero on the final position
      for (int k = 0; k < 15; k++)
         send_word(make_word(keep_nonzero(CLIMB_DELTAS[k]), (k == 0) ? 1'b0 : k[0]));
      send_word(make_word(zero_delta(), 1'b1));

      // 8x8 list, zero at the second position without default
      send_word(make_word(8'd0, 1'b1));
      send_word(make_word(8'hf8, 1'b0));

      // random lists with some noise
      while (words_sent < TOTAL_WORDS) begin
         if (!hold_done && words_sent > 150) begin
            // long receiver hold-off while deltas keep coming
            hold_seq <= hold_seq + 1;
            burst_left = 40;
            hold_done  = 1'b1;
         end
         if (!pause_done && words_sent > 300) begin
            sender_pause(0);
            wait_drained();
            pause_done = 1'b1;
         end
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            send_word(make_word(zero_delta(), 1'($urandom)));
         end else if (kind <= 7) begin
            send_list();
         end else begin
            noise = $urandom_range(1, 5);
            repeat (noise)
               send_word(make_word(8'($urandom), 1'($urandom)));
         end
      end

      // drain and let any stray fill run show up
      sender_pause(0);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (entry_board.mismatch_count == 0 && entry_board.pending_entries.size() == 0)
         $display("PASS scaling_list_delta_decoder_unit");
      else
         $display("FAIL scaling_list_delta_decoder_unit");
      $finish;
   end

   // time limit
   initial begin
      #10_000_000;
      $display("FAIL scaling_list_delta_decoder_unit");
      $finish;
   end

endmodule
